>>> rtl/strs_pkg.sv
// Shared types and constants for the segment tree range-sum block.
// No dependencies; the files that use it refer to this package by scoped names.
`default_nettype none

package strs_pkg;

  // Field widths fixed by the item format
  localparam int IDX_W  = 10;
  localparam int VAL_W  = 32;
  localparam int NCFG_W = 11;

  // Default element capacity and the reset value of the used-element count
  localparam int                MAX_ELEMENTS_DEF = 1024;
  localparam logic [NCFG_W-1:0] NUSED_RESET      = 11'd1024;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // One input beat as seen by the engine
  typedef struct packed {
    op_t                     op;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic [IDX_W-1:0]        query_start;
    logic [IDX_W-1:0]        query_end;
  } item_t;

  // Result handed from the engine to the output register
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] sum;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/strs_in_if.sv
// Input channel of the segment tree range-sum block: valid/ready plus item fields.
// Depends on strs_pkg for field widths.
`default_nettype none

interface strs_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [strs_pkg::IDX_W-1:0]       index;
  logic signed [strs_pkg::VAL_W-1:0] value;
  logic                             last;
  logic [strs_pkg::IDX_W-1:0]       query_start;
  logic [strs_pkg::IDX_W-1:0]       query_end;

  modport source (output valid, op, index, value, last, query_start, query_end,
                  input ready);
  modport sink   (input valid, op, index, value, last, query_start, query_end,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/strs_out_if.sv
// Result channel of the segment tree range-sum block: valid/ready plus the sum.
// Depends on strs_pkg for the sum width.
`default_nettype none

interface strs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [strs_pkg::VAL_W-1:0] sum;

  modport source (output valid, sum, input ready);
  modport sink   (input valid, sum, output ready);
endinterface

`default_nettype wire

>>> rtl/strs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module strs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read, read data registered for the next cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/strs_engine.sv
// Tree engine: clearing pass, point update walk and iterative range query
// over a heap-ordered node memory. Depends on strs_pkg and strs_ram.
`default_nettype none

module strs_engine #(
  parameter int MAX_ELEMENTS = strs_pkg::MAX_ELEMENTS_DEF,
  localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   clr_built,
  input  wire logic [CW-1:0]          n_eff,
  input  wire logic                   item_valid,
  output logic                        item_ready,
  input  wire strs_pkg::item_t        item,
  input  wire logic                   res_ready,
  output strs_pkg::res_t              res
);

  // Leaves sit at LEAF_BASE + index; node 1 is the root, node 0 unused
  localparam int LW        = $clog2(MAX_ELEMENTS);
  localparam int LEAF_BASE = 1 << LW;
  localparam int AW        = LW + 1;
  localparam int NW        = LW + 2;
  localparam int EW        = (CW > strs_pkg::IDX_W) ? CW : strs_pkg::IDX_W;
  localparam int VW        = strs_pkg::VAL_W;

  localparam logic [AW-1:0] ROOT   = AW'(1);
  localparam logic [NW-1:0] LB_N   = NW'(LEAF_BASE);
  localparam logic [AW-1:0] LB_A   = AW'(LEAF_BASE);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CLIMB = 5'b00100,
    S_QUERY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic            built_r, built_nxt;
  logic [AW-1:0]   p_r, p_nxt;
  logic [VW-1:0]   cur_r, cur_nxt;
  logic [NW-1:0]   l_r, l_nxt;
  logic [NW-1:0]   r_r, r_nxt;
  logic [VW-1:0]   acc_r, acc_nxt;
  logic            pend_r, pend_nxt;

  logic            we, re;
  logic [AW-1:0]   waddr, raddr;
  logic [VW-1:0]   wdata, rdata;

  logic [EW-1:0]   qs_x, qe_x, nm1_x, qe_c;
  logic            q_empty;
  logic            idx_ok;
  logic [AW-1:0]   leaf;
  logic [AW-1:0]   q_par;
  logic [VW-1:0]   climb_sum;
  logic [VW-1:0]   acc_add;
  logic            l_lt_r;

  strs_ram #(
    .WIDTH (VW),
    .DEPTH (2 * LEAF_BASE)
  ) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Clamp the query end to the last used element
  assign qs_x    = EW'(item.query_start);
  assign qe_x    = EW'(item.query_end);
  assign nm1_x   = EW'(n_eff - CW'(1));
  assign qe_c    = (qe_x < nm1_x) ? qe_x : nm1_x;
  assign q_empty = (qs_x > qe_c);

  assign idx_ok    = (32'(item.index) < MAX_ELEMENTS);
  assign leaf      = LB_A | AW'(item.index);
  assign q_par     = p_r >> 1;
  assign climb_sum = cur_r + rdata;
  assign acc_add   = acc_r + (pend_r ? rdata : '0);
  assign l_lt_r    = (l_r < r_r);

  assign item_ready = (state_r == S_IDLE);
  assign res.valid  = (state_r == S_DONE);
  assign res.sum    = acc_r;

  // Next state and memory accesses
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    built_nxt = built_r;
    p_nxt     = p_r;
    cur_nxt   = cur_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    re        = 1'b0;
    raddr     = '0;

    unique case (state_r)
      S_CLEAR: begin
        // Zero every node: an all-zero tree matches all-zero elements
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          if (item.op == strs_pkg::OP_LOAD) begin
            built_nxt = item.last;
            if (idx_ok) begin
              // Write the leaf and fetch its sibling
              we        = 1'b1;
              waddr     = leaf;
              wdata     = item.value;
              re        = 1'b1;
              raddr     = leaf ^ AW'(1);
              p_nxt     = leaf;
              cur_nxt   = item.value;
              state_nxt = S_CLIMB;
            end
          end else if (!built_r || q_empty) begin
            acc_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            l_nxt     = LB_N + NW'(qs_x);
            r_nxt     = LB_N + NW'(qe_c) + NW'(1);
            acc_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_QUERY;
          end
        end
      end
      S_CLIMB: begin
        // Refresh the parent, then fetch the parent's sibling unless the parent is the root
        we      = 1'b1;
        waddr   = q_par;
        wdata   = climb_sum;
        p_nxt   = q_par;
        cur_nxt = climb_sum;
        if (q_par == ROOT) begin
          state_nxt = S_IDLE;
        end else begin
          re    = 1'b1;
          raddr = q_par ^ AW'(1);
        end
      end
      S_QUERY: begin
        // Fold in last cycle's read, then take one bound step
        acc_nxt  = acc_add;
        pend_nxt = 1'b0;
        priority if (l_lt_r && l_r[0]) begin
          re       = 1'b1;
          raddr    = l_r[AW-1:0];
          l_nxt    = l_r + NW'(1);
          pend_nxt = 1'b1;
        end else if (l_lt_r && r_r[0]) begin
          re       = 1'b1;
          raddr    = AW'(r_r - NW'(1));
          r_nxt    = r_r - NW'(1);
          pend_nxt = 1'b1;
        end else if (l_lt_r) begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // A register write makes the tree stale
    if (clr_built) begin
      built_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      built_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      built_r <= built_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Walk and accumulator registers
  always_ff @(posedge clk) begin
    p_r   <= p_nxt;
    cur_r <= cur_nxt;
    l_r   <= l_nxt;
    r_r   <= r_nxt;
    acc_r <= acc_nxt;
  end

  // Same-cycle read and write never touch one node
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (we && re) |-> (waddr != raddr))
    else $error("node read and written in the same cycle");

  // Update walk never writes the unused node
  a_climb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLIMB) |-> (waddr != '0))
    else $error("update walk wrote node zero");

  // Query reads stay on real nodes
  a_query_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (re && state_r == S_QUERY) |-> (raddr != '0))
    else $error("query read node zero");

  // A waiting result holds its sum
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && !res_ready) |=> (res.valid && $stable(res.sum)))
    else $error("pending result changed");

endmodule

`default_nettype wire

>>> rtl/segment_tree_range_sum_top.sv
// Load: accepted, then every node on the path from the leaf up to the root is refreshed.
// P is MAX_ELEMENTS rounded up to a power of two.
// Query: iterative bound walk with at most one node memory read per step; result
//   registered, next item accepted while it waits.
// Reset (rst_n, synchronous): clearing pass over all 2*P nodes of the node memory
//   (2048 nodes for 1024 elements) with input ready low; n_used resets to 1024.
// Top level of the segment tree range-sum block: config register, output register.
// Depends on strs_pkg, strs_in_if, strs_out_if and strs_engine.
`default_nettype none

module segment_tree_range_sum_top #(
  parameter int MAX_ELEMENTS = strs_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  strs_in_if.sink                            in_ch,
  strs_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [strs_pkg::NCFG_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic [strs_pkg::NCFG_W-1:0]        n_used_r;
  logic [CW-1:0]                      n_eff;
  strs_pkg::item_t                    item;
  strs_pkg::res_t                     res;
  logic                               res_ready;
  logic                               out_valid_r;
  logic signed [strs_pkg::VAL_W-1:0]  out_sum_r;

  // Hold the used-element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_used_r <= strs_pkg::NUSED_RESET;
    end else if (cfg_we) begin
      n_used_r <= cfg_wdata;
    end
  end

  // Clamp the count to 1..MAX_ELEMENTS
  always_comb begin
    priority if (n_used_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(n_used_r) > MAX_ELEMENTS) begin
      n_eff = CW'(MAX_ELEMENTS);
    end else begin
      n_eff = CW'(n_used_r);
    end
  end

  assign item.op          = strs_pkg::op_t'(in_ch.op);
  assign item.index       = in_ch.index;
  assign item.value       = in_ch.value;
  assign item.last        = in_ch.last;
  assign item.query_start = in_ch.query_start;
  assign item.query_end   = in_ch.query_end;

  strs_engine #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .clr_built  (cfg_we),
    .n_eff      (n_eff),
    .item_valid (in_ch.valid),
    .item_ready (in_ch.ready),
    .item       (item),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: take a new result when empty or draining
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_sum_r <= res.sum;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.sum   = out_sum_r;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for segment_tree_range_sum_top: element loads, tree builds
// and range-sum queries, checked beat by beat against a shadow copy of the elements.
// Depends on strs_pkg, strs_in_if, strs_out_if and the block's RTL.

module testbench;

  localparam int IDX_W            = strs_pkg::IDX_W;
  localparam int VAL_W            = strs_pkg::VAL_W;
  localparam int NCFG_W           = strs_pkg::NCFG_W;
  localparam int CLK_HALF         = 5;
  localparam int NUM_ELEMS        = strs_pkg::MAX_ELEMENTS_DEF;
  localparam int SETTLE_CYCLES    = 64;
  localparam int DRAIN_LIMIT      = 200000;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int LONG_HOLD_CYCLES = 400;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [NCFG_W-1:0] cfg_wdata;

  strs_in_if  in_ch();
  strs_out_if out_ch();

  segment_tree_range_sum_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block: element store, used count and tree-valid flag
  logic [VAL_W-1:0] elem_shadow [NUM_ELEMS];
  int unsigned      n_used_shadow;
  bit               tree_built;

  logic [VAL_W-1:0]      expected_sums [$];
  strs_pkg::item_t       pending_items [$];
  strs_pkg::item_t       offered_item;
  int unsigned      items_queued   = 0;
  int unsigned      items_accepted = 0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          long_hold_req   = 1'b0;
  bit          long_hold_taken = 1'b0;
  int unsigned hold_left       = 0;

  int unsigned      mismatches  = 0;
  int unsigned      cycle_count = 0;
  logic [VAL_W-1:0] exp_sum;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Number of elements the tree spans, with the register clamped to 1..capacity
  function automatic int unsigned covered_count();
    if (n_used_shadow == 0) return 1;
    if (n_used_shadow > NUM_ELEMS) return NUM_ELEMS;
    return n_used_shadow;
  endfunction

  // Wrapped sum of the used elements that fall in [qs, qe]
  function automatic logic [VAL_W-1:0] range_sum(int unsigned qs, int unsigned qe);
    logic [VAL_W-1:0] acc;
    int unsigned      top_idx;
    acc = '0;
    top_idx = covered_count() - 1;
    if (qe < top_idx) top_idx = qe;
    for (int unsigned i = qs; i <= top_idx; i++) acc += elem_shadow[i];
    return acc;
  endfunction

  // Apply one accepted beat; a query always produces one sum
  function automatic void track_item(strs_pkg::item_t it);
    if (it.op == strs_pkg::OP_LOAD) begin
      elem_shadow[it.index] = it.value;
      tree_built = it.last;
    end else if (tree_built && it.query_start <= it.query_end) begin
      expected_sums.push_back(range_sum(32'(it.query_start), 32'(it.query_end)));
    end else begin
      expected_sums.push_back('0);
    end
  endfunction

  // Input driver: hold a beat until taken, otherwise offer the next item or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_item(offered_item);
        items_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offered_item = pending_items.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.op          <= offered_item.op;
          in_ch.index       <= offered_item.index;
          in_ch.value       <= offered_item.value;
          in_ch.last        <= offered_item.last;
          in_ch.query_start <= offered_item.query_start;
          in_ch.query_end   <= offered_item.query_end;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random back-pressure plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken <= 1'b1;
      hold_left       <= LONG_HOLD_CYCLES;
      out_ch.ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result monitor: compare every sum beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected sum beat: expected none, actual %0d",
                 $time, $signed(out_ch.sum));
        mismatches++;
      end else begin
        exp_sum = expected_sums.pop_front();
        if (out_ch.sum !== exp_sum) begin
          $display("%0t: sum mismatch: expected %0d, actual %0d",
                   $time, $signed(exp_sum), $signed(out_ch.sum));
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL segment_tree_range_sum_top");
      $finish;
    end
  end

  task automatic push_load(int unsigned idx, logic [VAL_W-1:0] val, bit is_last);
    strs_pkg::item_t it;
    it.op          = strs_pkg::OP_LOAD;
    it.index       = IDX_W'(idx);
    it.value       = val;
    it.last        = is_last;
    it.query_start = IDX_W'($urandom_range(0, 1023));
    it.query_end   = IDX_W'($urandom_range(0, 1023));
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_query(int unsigned qs, int unsigned qe);
    strs_pkg::item_t it;
    it.op          = strs_pkg::OP_QUERY;
    it.index       = IDX_W'($urandom_range(0, 1023));
    it.value       = $urandom;
    it.last        = 1'($urandom_range(0, 1));
    it.query_start = IDX_W'(qs);
    it.query_end   = IDX_W'(qe);
    pending_items.push_back(it);
    items_queued++;
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    unique case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Mostly inside the used range, sometimes anywhere
  function automatic int unsigned pick_index(int unsigned n);
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, n - 1);
    return $urandom_range(0, 1023);
  endfunction

  task automatic push_random_query(int unsigned n);
    int unsigned qs;
    int unsigned qe;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      qs = $urandom_range(0, n - 1);
      qe = $urandom_range(qs, n - 1);
    end else if (sel < 8) begin
      // run past the used elements
      qs = $urandom_range(0, n - 1);
      qe = $urandom_range(qs, 1023);
    end else if (sel == 8) begin
      qs = 0;
      qe = 1023;
    end else begin
      qs = $urandom_range(0, 1023);
      qe = $urandom_range(0, 1023);
    end
    push_query(qs, qe);
  endtask

  task automatic push_session(int unsigned n, inout int unsigned produced);
    int unsigned loads;
    int unsigned queries;
    int unsigned kind;
    kind    = $urandom_range(0, 99);
    loads   = $urandom_range(0, (n < 12) ? n : 12);
    queries = $urandom_range(2, 10);
    if (kind < 85) begin
      // well-formed: some loads, the build, then queries
      for (int i = 0; i < loads; i++) push_load(pick_index(n), rand_value(), 1'b0);
      push_load(pick_index(n), rand_value(), 1'b1);
      for (int i = 0; i < queries; i++) push_random_query(n);
      produced += loads + 1 + queries;
    end else if (kind < 95) begin
      // broken: a stray load after the build leaves the tree stale
      push_load(pick_index(n), rand_value(), 1'b1);
      push_load(pick_index(n), rand_value(), 1'b0);
      for (int i = 0; i < queries; i++) push_random_query(n);
      produced += 2 + queries;
    end else begin
      // noise: any op with any fields
      for (int i = 0; i < queries; i++) begin
        if ($urandom_range(0, 1) != 0)
          push_query($urandom_range(0, 1023), $urandom_range(0, 1023));
        else
          push_load($urandom_range(0, 1023), $urandom, 1'($urandom_range(0, 1)));
      end
      produced += queries;
    end
  endtask

  // Wait until every item is taken and every sum has come back (or the drain limit runs out), then let loads settle
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    while ((items_accepted != items_queued || expected_sums.size() != 0) &&
           waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_n_used(logic [NCFG_W-1:0] n_raw);
    cfg_we    <= 1'b1;
    cfg_wdata <= n_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_used_shadow = 32'(n_raw);
    tree_built    = 1'b0;
  endtask

  task automatic run_segment(logic [NCFG_W-1:0] n_raw, int unsigned n_items);
    int unsigned produced;
    int unsigned n_eff;
    write_n_used(n_raw);
    n_eff = covered_count();
    // the register write leaves the tree stale
    push_random_query(n_eff);
    produced = 1;
    while (produced < n_items) push_session(n_eff, produced);
    wait_idle();
  endtask

  // Directed part at the reset size of 1024 elements
  task automatic directed_checks();
    // query before any build
    push_query(0, 1023);
    push_load(0, 32'h7FFF_FFFF, 1'b0);
    push_load(1023, 32'h8000_0000, 1'b0);
    push_load(1, 32'hFFFF_FFFF, 1'b0);
    push_load(512, 32'h0000_0001, 1'b1);
    // full range, wrap-around, single ends, inverted and never-loaded entries
    push_query(0, 1023);
    push_query(0, 1);
    push_query(1023, 1023);
    push_query(0, 0);
    push_query(1, 0);
    push_query(1023, 0);
    push_query(5, 5);
    push_query(512, 1023);
    push_query(2, 511);
    // a load that is not last makes the tree stale
    push_load(3, 32'h0000_0005, 1'b0);
    push_query(0, 1023);
    push_load(3, 32'h0000_0005, 1'b1);
    push_query(3, 3);
    push_query(0, 1023);
    wait_idle();
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.op          = strs_pkg::OP_LOAD;
    in_ch.index       = '0;
    in_ch.value       = '0;
    in_ch.last        = 1'b0;
    in_ch.query_start = '0;
    in_ch.query_end   = '0;
    out_ch.ready      = 1'b0;
    for (int i = 0; i < NUM_ELEMS; i++) elem_shadow[i] = '0;
    n_used_shadow = 32'(strs_pkg::NUSED_RESET);
    tree_built    = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    tx_idle_pct = 11;
    rx_idle_pct = 66;
    directed_checks();
    run_segment(11'd2047, 200);
    run_segment(11'd1, 150);
    run_segment(11'd37, 200);

    // sender idles heavily, receiver lightly
    tx_idle_pct = 66;
    rx_idle_pct = 11;
    run_segment(11'd0, 100);
    run_segment(11'd1024, 200);
    run_segment(11'd2, 150);
    run_segment(NCFG_W'($urandom_range(3, 200)), 200);

    // no idling; the receiver holds off once so the block backs up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    long_hold_req <= 1'b1;
    run_segment(11'd64, 200);
    run_segment(11'd1023, 200);
    run_segment(NCFG_W'($urandom_range(0, 2047)), 200);
    run_segment(11'd513, 50);

    if (expected_sums.size() != 0) begin
      $display("%0t: %0d sums still expected at end of run, actual none",
               $time, expected_sums.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("PASS segment_tree_range_sum_top");
    end else begin
      $display("FAIL segment_tree_range_sum_top");
    end
    $finish;
  end

endmodule

>>> segment_tree_range_sum_top.f
rtl/strs_pkg.sv
rtl/strs_in_if.sv
rtl/strs_out_if.sv
rtl/strs_ram.sv
rtl/strs_engine.sv
rtl/segment_tree_range_sum_top.sv
dv/testbench.sv
